// ----- rtl/cfm64_pkg.sv -----
// cfm64_pkg: types, constants and lane functions for the case-folded murmur64a hash
// used by cfm64_ctrl, cfm64_dpath and case_folded_murmur64a_hash; no dependencies
`timescale 1ns / 1ps
package cfm64_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  // source of the multiplier operand register
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LEN,
    OP_FOLD,
    OP_XS,
    OP_HXK,
    OP_HXT,
    OP_HXS
  } op_sel_t;

  typedef struct packed {
    logic       load;
    op_sel_t    op_sel;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       h_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic empty;
  } stat_t;

  function automatic logic [63:0] fold_case(input logic [63:0] w);
    logic [63:0] r;
    logic [7:0]  b;
    r = '0;
    for (int lane = 0; lane < 8; lane++) begin
      b = w[lane*8 +: 8];
      if (b >= 8'h41 && b <= 8'h5a) begin
        b = b | 8'h20;
      end
      r[lane*8 +: 8] = b;
    end
    return r;
  endfunction

  function automatic logic [63:0] tail_mask(input logic [2:0] cnt);
    logic [63:0] m;
    m = (64'h1 << {cnt, 3'b000}) - 64'h1;
    return m;
  endfunction

endpackage

// ----- rtl/cfm64_dpath.sv -----
// cfm64_dpath: item registers, running hash, shared 32x32 multiplier and result register
// depends on cfm64_pkg; driven by cmd_t from cfm64_ctrl
`timescale 1ns / 1ps
module cfm64_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  cfm64_pkg::cmd_t    cmd,
  input  logic [63:0]        in_word,
  input  logic [3:0]         in_byte_count,
  input  logic               in_first,
  input  logic               in_last,
  input  logic [15:0]        in_total_length,
  output cfm64_pkg::stat_t   stat,
  output logic [63:0]        hash
);
  import cfm64_pkg::*;

  logic [63:0] w_r;
  logic [3:0]  cnt_r;
  logic        first_r;
  logic        last_r;
  logic [15:0] len_r;
  logic [63:0] op_r, op_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] h_r;
  logic [63:0] hash_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // low 64 bits of op * MIX_MUL in three partial products
  always_comb begin
    mul_a = (cmd.mul_step == 2'd2) ? op_r[63:32] : op_r[31:0];
    mul_b = (cmd.mul_step == 2'd1) ? MIX_MUL[63:32] : MIX_MUL[31:0];
    prod  = {32'b0, mul_a} * {32'b0, mul_b};
    if (cmd.mul_step == 2'd0) begin
      acc_nxt = prod;
    end else begin
      acc_nxt = acc_r + {prod[31:0], 32'b0};
    end
  end

  always_comb begin
    case (cmd.op_sel)
      OP_HOLD: op_nxt = op_r;
      OP_LEN:  op_nxt = {48'b0, len_r};
      OP_FOLD: op_nxt = fold_case(w_r);
      OP_XS:   op_nxt = acc_r ^ (acc_r >> MIX_SHIFT);
      OP_HXK:  op_nxt = h_r ^ acc_r;
      OP_HXT:  op_nxt = h_r ^ (fold_case(w_r) & tail_mask(cnt_r[2:0]));
      OP_HXS:  op_nxt = h_r ^ (h_r >> MIX_SHIFT);
      default: op_nxt = op_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r     <= in_word;
      cnt_r   <= in_byte_count;
      first_r <= in_first;
      last_r  <= in_last;
      len_r   <= in_total_length;
    end
    op_r <= op_nxt;
    if (cmd.mul_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.out_load) begin
      hash_r <= acc_r ^ (acc_r >> MIX_SHIFT);
    end
  end

  // running hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
    end else if (cmd.h_load) begin
      h_r <= acc_r;
    end
  end

  assign stat.first = first_r;
  assign stat.last  = last_r;
  assign stat.full  = cnt_r[3];
  assign stat.empty = (cnt_r == 4'd0);
  assign hash       = hash_r;

endmodule

// ----- rtl/cfm64_ctrl.sv -----
// cfm64_ctrl: sequencer for seed, word mix, tail, finalize and result handoff
// depends on cfm64_pkg; drives cfm64_dpath through cmd_t
`timescale 1ns / 1ps
module cfm64_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  cfm64_pkg::stat_t   stat,
  output cfm64_pkg::cmd_t    cmd
);
  import cfm64_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_BODY,
    S_FIN,
    S_MUL,
    S_POST
  } state_t;

  typedef enum logic [2:0] {
    PH_SEED,
    PH_K1,
    PH_K2,
    PH_H,
    PH_OUT
  } phase_t;

  state_t     state_r, state_nxt;
  phase_t     ph_r, ph_nxt;
  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    step_nxt      = 2'd0;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.op_sel    = OP_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.first) begin
          cmd.op_sel = OP_LEN;
          ph_nxt     = PH_SEED;
          state_nxt  = S_MUL;
        end else begin
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        if (stat.full) begin
          cmd.op_sel = OP_FOLD;
          ph_nxt     = PH_K1;
          state_nxt  = S_MUL;
        end else if (!stat.empty) begin
          cmd.op_sel = OP_HXT;
          ph_nxt     = PH_H;
          state_nxt  = S_MUL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.last) begin
          cmd.op_sel = OP_HXS;
          ph_nxt     = PH_OUT;
          state_nxt  = S_MUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = step_r;
        if (step_r == 2'd2) begin
          state_nxt = S_POST;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      S_POST: begin
        case (ph_r)
          PH_SEED: begin
            cmd.h_load = 1'b1;
            state_nxt  = S_BODY;
          end
          PH_K1: begin
            cmd.op_sel = OP_XS;
            ph_nxt     = PH_K2;
            state_nxt  = S_MUL;
          end
          PH_K2: begin
            cmd.op_sel = OP_HXK;
            ph_nxt     = PH_H;
            state_nxt  = S_MUL;
          end
          PH_H: begin
            cmd.h_load = 1'b1;
            state_nxt  = S_FIN;
          end
          PH_OUT: begin
            // wait until the result register is free
            if (!out_valid_r || out_tready) begin
              cmd.out_load  = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_SEED;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- rtl/case_folded_murmur64a_hash.sv -----
// channel | dir | tdata                                   | tlast | tuser
// in_     | in  | word, byte_count, total_length (88 bits) | last  | first
// out_    | out | hash (64 bits)                          | -     | -
//
// one word passes through accept, first check, body and finish, one state each;
// each 64-bit multiply is three passes through one shared 32x32 multiplier plus
// one routing step; a full word needs three multiplies, a tail word one, a first
// word one more for the seed, a last word one more for the finalize
// rst_n is synchronous; it clears the sequencer, result valid and running hash
// a finished hash waits in the output register while the next word is taken;
// only the next hash stalls until out_tready drains it
// top level of the case-folded murmur64a hash; depends on cfm64_pkg,
// cfm64_ctrl and cfm64_dpath
`timescale 1ns / 1ps
module case_folded_murmur64a_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // word[63:0], byte_count[67:64], total_length[83:68], zero
  input  logic        in_tlast,
  input  logic [0:0]  in_tuser,   // first[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // hash[63:0]
);
  import cfm64_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cfm64_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cfm64_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_word         (in_tdata[63:0]),
    .in_byte_count   (in_tdata[67:64]),
    .in_first        (in_tuser[0]),
    .in_last         (in_tlast),
    .in_total_length (in_tdata[83:68]),
    .stat            (stat),
    .hash            (out_tdata)
  );

`ifndef SYNTH
  a_mul_seq : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en && cmd.mul_step == 2'd0 |=> cmd.mul_en && cmd.mul_step == 2'd1)
    else $error("multiply passes out of order");

  a_mul_end : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en && cmd.mul_step == 2'd2 |=> !cmd.mul_en)
    else $error("multiply ran past its last pass");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_tvalid || out_tready)
    else $error("pending hash overwritten");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word taken while busy");
`endif

endmodule
